[hdl/xts_pkg.sv]
// xts_pkg: shared types, aes tables and round functions for the xts sector cipher
// no dependencies; imported by every module of the block but xts_chk
package xts_pkg;

    typedef struct packed {
        logic [63:0] data_lo;
        logic [63:0] data_hi;
        logic [63:0] iv_lo;
        logic [63:0] iv_hi;
        logic        do_encrypt;
        logic        first_block;
        logic        last_block;
        logic        partial;
        logic [4:0]  valid_bytes;
    } t_item;

    typedef struct packed {
        logic [63:0] out_lo;
        logic [63:0] out_hi;
        logic [4:0]  out_bytes;
        logic        out_last;
        logic        error;
    } t_res;

    typedef struct packed {
        logic start;
        logic enc;
        logic sel_tw;
    } t_aes_req;

    localparam logic [4:0]   FULL_BYTES = 5'd16;
    localparam logic [127:0] GF_POLY    = 128'h87;
    localparam logic [7:0]   RC_INIT    = 8'h01;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                t[8*(w+4*c) +: 8] = SBOX[s[8*(w+4*((c+w)%4)) +: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                t[8*(w+4*((c+w)%4)) +: 8] = INV_SBOX[s[8*(w+4*c) +: 8]];
            end
        end
        inv_sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[32*c +: 8];
            a1 = s[32*c+8 +: 8];
            a2 = s[32*c+16 +: 8];
            a3 = s[32*c+24 +: 8];
            t[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_cols = t;
    endfunction

    // multiply by 9, 11, 13, 14 from the x2, x4, x8 terms
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [1:0] k);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        unique case (k)
            2'd0:    gm = x8 ^ a;
            2'd1:    gm = x8 ^ x2 ^ a;
            2'd2:    gm = x8 ^ x4 ^ a;
            default: gm = x8 ^ x4 ^ x2;
        endcase
    endfunction

    localparam logic [1:0] G9 = 2'd0, G11 = 2'd1, G13 = 2'd2, G14 = 2'd3;

    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[32*c +: 8];
            a1 = s[32*c+8 +: 8];
            a2 = s[32*c+16 +: 8];
            a3 = s[32*c+24 +: 8];
            t[32*c +: 8]    = gm(a0, G14) ^ gm(a1, G11) ^ gm(a2, G13) ^ gm(a3, G9);
            t[32*c+8 +: 8]  = gm(a0, G9) ^ gm(a1, G14) ^ gm(a2, G11) ^ gm(a3, G13);
            t[32*c+16 +: 8] = gm(a0, G13) ^ gm(a1, G9) ^ gm(a2, G14) ^ gm(a3, G11);
            t[32*c+24 +: 8] = gm(a0, G11) ^ gm(a1, G13) ^ gm(a2, G9) ^ gm(a3, G14);
        end
        inv_mix_cols = t;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] rot_sub(input logic [31:0] w, input logic [7:0] rc);
        rot_sub = {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rc};
    endfunction

endpackage

[hdl/xts_aes_sector_cipher_core.sv]
// xts_aes_sector_cipher_core: top level, apb key registers and block wiring
// instantiates xts_front, xts_kexp, xts_aes and xts_back; uses xts_pkg
//
// input channel (i_in_valid / o_in_ready) takes one 16-byte block request per
// transfer with sector delimiters; output channel (o_out_valid / i_out_ready)
// returns result blocks, up to two per request, with byte count, last and error.
// one block is held back per sector, so a non-last block yields its result
// when the next block arrives.
// timing: each aes pass runs one round per cycle in the shared round unit
// (NR = 10, 12, 14). a first block adds a pass for the tweak encryption;
// a full last block with a block held needs two passes, a partial last
// block two dependent passes with stealing.
// a two-entry request queue and a two-entry result queue decouple the sides:
// requests are taken while results wait, and a stalled receiver only stops
// the sequencer once the result queue is full.
// keys are written over apb (64-bit registers at 8*i); after reset and after
// any key write the schedules are re-expanded before the next request is
// processed. reset clears the tweak, held block and queues.
module xts_aes_sector_cipher_core #(
    parameter int KEY_BITS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_data_lo,
    input  logic [63:0] i_data_hi,
    input  logic [63:0] i_iv_lo,
    input  logic [63:0] i_iv_hi,
    input  logic        i_do_encrypt,
    input  logic        i_first_block,
    input  logic        i_last_block,
    input  logic [4:0]  i_valid_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_lo,
    output logic [63:0] o_out_hi,
    output logic [4:0]  o_out_bytes,
    output logic        o_out_last,
    output logic        o_error
);
    import xts_pkg::*;

    localparam int NK = (KEY_BITS <= 128) ? 4 : ((KEY_BITS <= 192) ? 6 : 8);
    localparam int NR = NK + 6;
    localparam int RW = $clog2(NR + 1);

    logic [63:0]   r_dkey [4];
    logic [63:0]   r_tkey [4];
    logic          w_wr;
    logic [2:0]    w_idx;

    t_item         w_item;
    logic          w_item_valid, w_pop;
    logic          w_kexp_start, w_dk_busy, w_tk_busy;
    t_aes_req      w_aes_req;
    logic [127:0]  w_aes_din, w_aes_dout, w_dk_row, w_tk_row;
    logic          w_aes_done;
    logic [RW-1:0] w_rk_addr;
    t_res          w_res;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_dkey[k] <= '0;
                r_tkey[k] <= '0;
            end
        end else if (w_wr) begin
            if (w_idx[2]) begin
                r_tkey[w_idx[1:0]] <= pwdata;
            end else begin
                r_dkey[w_idx[1:0]] <= pwdata;
            end
        end
    end

    assign prdata = w_idx[2] ? r_tkey[w_idx[1:0]] : r_dkey[w_idx[1:0]];

    xts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_lo     (i_data_lo),
        .i_data_hi     (i_data_hi),
        .i_iv_lo       (i_iv_lo),
        .i_iv_hi       (i_iv_hi),
        .i_do_encrypt  (i_do_encrypt),
        .i_first_block (i_first_block),
        .i_last_block  (i_last_block),
        .i_valid_bytes (i_valid_bytes),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_pop         (w_pop)
    );

    xts_kexp #(.KEY_BITS(KEY_BITS)) u_kexp_data (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_kexp_start),
        .i_key   ({r_dkey[3], r_dkey[2], r_dkey[1], r_dkey[0]}),
        .i_addr  (w_rk_addr),
        .o_row   (w_dk_row),
        .o_busy  (w_dk_busy)
    );

    xts_kexp #(.KEY_BITS(KEY_BITS)) u_kexp_tweak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_kexp_start),
        .i_key   ({r_tkey[3], r_tkey[2], r_tkey[1], r_tkey[0]}),
        .i_addr  (w_rk_addr),
        .o_row   (w_tk_row),
        .o_busy  (w_tk_busy)
    );

    xts_aes #(.KEY_BITS(KEY_BITS)) u_aes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_aes_req),
        .i_din     (w_aes_din),
        .o_rk_addr (w_rk_addr),
        .i_dk_row  (w_dk_row),
        .i_tk_row  (w_tk_row),
        .o_dout    (w_aes_dout),
        .o_done    (w_aes_done)
    );

    xts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .i_cfg_wr     (w_wr),
        .o_kexp_start (w_kexp_start),
        .i_kexp_busy  (w_dk_busy || w_tk_busy),
        .o_aes_req    (w_aes_req),
        .o_aes_din    (w_aes_din),
        .i_aes_dout   (w_aes_dout),
        .i_aes_done   (w_aes_done),
        .o_res        (w_res),
        .o_res_valid  (o_out_valid),
        .i_res_ready  (i_out_ready)
    );

    assign o_out_lo    = w_res.out_lo;
    assign o_out_hi    = w_res.out_hi;
    assign o_out_bytes = w_res.out_bytes;
    assign o_out_last  = w_res.out_last;
    assign o_error     = w_res.error;

endmodule

[hdl/xts_front.sv]
// xts_front: accepts input requests, normalizes the byte count and flags partial blocks
// feeds a two-entry queue toward the back end; uses xts_pkg
module xts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [63:0]    i_data_lo,
    input  logic [63:0]    i_data_hi,
    input  logic [63:0]    i_iv_lo,
    input  logic [63:0]    i_iv_hi,
    input  logic           i_do_encrypt,
    input  logic           i_first_block,
    input  logic           i_last_block,
    input  logic [4:0]     i_valid_bytes,
    output xts_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_pop
);
    import xts_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;
    logic       w_full_len;

    // zero, sixteen and above, or any non-last block count as a full block
    assign w_full_len = (i_valid_bytes == 5'd0) || (i_valid_bytes >= FULL_BYTES) || !i_last_block;

    always_comb begin
        w_item.data_lo     = i_data_lo;
        w_item.data_hi     = i_data_hi;
        w_item.iv_lo       = i_iv_lo;
        w_item.iv_hi       = i_iv_hi;
        w_item.do_encrypt  = i_do_encrypt;
        w_item.first_block = i_first_block;
        w_item.last_block  = i_last_block;
        w_item.partial     = !w_full_len;
        w_item.valid_bytes = w_full_len ? FULL_BYTES : i_valid_bytes;
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

[hdl/xts_kexp.sv]
// xts_kexp: aes key expansion, one schedule word per cycle into a round key row file
// read combinationally by the round unit; uses xts_pkg
module xts_kexp #(
    parameter int KEY_BITS = 256,
    localparam int NK  = (KEY_BITS <= 128) ? 4 : ((KEY_BITS <= 192) ? 6 : 8),
    localparam int NR  = NK + 6,
    localparam int RW  = $clog2(NR + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [255:0]  i_key,
    input  logic [RW-1:0] i_addr,
    output logic [127:0]  o_row,
    output logic          o_busy
);
    import xts_pkg::*;

    localparam int TOTAL = 4 * (NR + 1);
    localparam int CW    = $clog2(TOTAL);

    logic [127:0]  r_rows [NR+1];
    logic [31:0]   r_win [8];
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_mod;
    logic [7:0]    r_rc;
    logic          r_busy;
    logic [31:0]   w_word, w_tmp;
    logic          w_init;

    assign w_init = (r_cnt < CW'(NK));

    always_comb begin
        priority if (r_mod == 3'd0) begin
            w_tmp = rot_sub(r_win[0], r_rc);
        end else if (NK > 6 && r_mod == 3'd4) begin
            w_tmp = sub_word(r_win[0]);
        end else begin
            w_tmp = r_win[0];
        end
        w_word = w_init ? i_key[32*r_cnt[2:0] +: 32] : (r_win[NK-1] ^ w_tmp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_mod  <= 3'd0;
            r_rc   <= RC_INIT;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_mod  <= 3'd0;
            r_rc   <= RC_INIT;
        end else if (r_busy) begin
            r_mod <= (r_mod == 3'(NK - 1)) ? 3'd0 : r_mod + 3'd1;
            if (!w_init && r_mod == 3'd0) begin
                r_rc <= xtime(r_rc);
            end
            if (r_cnt == CW'(TOTAL - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= w_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_rows[RW'(r_cnt >> 2)][32*r_cnt[1:0] +: 32] <= w_word;
        end
    end

    assign o_row  = r_rows[i_addr];
    assign o_busy = r_busy;

endmodule

[hdl/xts_aes.sv]
// xts_aes: iterative aes round unit, one round per cycle, encrypt or decrypt
// takes round keys from the data and tweak key files; uses xts_pkg
module xts_aes #(
    parameter int KEY_BITS = 256,
    localparam int NK = (KEY_BITS <= 128) ? 4 : ((KEY_BITS <= 192) ? 6 : 8),
    localparam int NR = NK + 6,
    localparam int RW = $clog2(NR + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xts_pkg::t_aes_req i_req,
    input  logic [127:0]      i_din,
    output logic [RW-1:0]     o_rk_addr,
    input  logic [127:0]      i_dk_row,
    input  logic [127:0]      i_tk_row,
    output logic [127:0]      o_dout,
    output logic              o_done
);
    import xts_pkg::*;

    localparam logic [RW-1:0] LAST = RW'(NR);

    logic          r_busy, r_enc, r_sel, r_done;
    logic [RW-1:0] r_round;
    logic [127:0]  r_s;
    logic [127:0]  w_rk, w_enc_t, w_dec_t;
    logic          w_sel;

    assign w_sel     = r_busy ? r_sel : i_req.sel_tw;
    assign o_rk_addr = r_busy ? r_round : (i_req.enc ? '0 : LAST);
    assign w_rk      = w_sel ? i_tk_row : i_dk_row;

    always_comb begin
        w_enc_t = sub_shift(r_s);
        if (r_round != LAST) begin
            w_enc_t = mix_cols(w_enc_t);
        end
        w_enc_t = w_enc_t ^ w_rk;
        w_dec_t = inv_sub_shift(r_s) ^ w_rk;
        if (r_round != '0) begin
            w_dec_t = inv_mix_cols(w_dec_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_enc   <= 1'b0;
            r_sel   <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_enc   <= i_req.enc;
                r_sel   <= i_req.sel_tw;
                r_round <= i_req.enc ? RW'(1) : LAST - 1'b1;
            end else if (r_busy) begin
                if (r_enc) begin
                    if (r_round == LAST) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end else begin
                    if (r_round == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_round <= r_round - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_s <= i_din ^ w_rk;
        end else if (r_busy) begin
            r_s <= r_enc ? w_enc_t : w_dec_t;
        end
    end

    assign o_dout = r_s;
    assign o_done = r_done;

endmodule

[hdl/xts_back.sv]
// xts_back: sector sequencer: tweak chain, held block, ciphertext stealing, result queue
// drives xts_aes and the key expanders; uses xts_pkg
module xts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xts_pkg::t_item    i_item,
    input  logic              i_item_valid,
    output logic              o_pop,
    input  logic              i_cfg_wr,
    output logic              o_kexp_start,
    input  logic              i_kexp_busy,
    output xts_pkg::t_aes_req o_aes_req,
    output logic [127:0]      o_aes_din,
    input  logic [127:0]      i_aes_dout,
    input  logic              i_aes_done,
    output xts_pkg::t_res     o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);
    import xts_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_KEY = 4'd1, ST_TWK = 4'd2, ST_DISP = 4'd3,
                           ST_H = 4'd4, ST_HP = 4'd5, ST_L = 4'd6, ST_LP = 4'd7,
                           ST_P1 = 4'd8, ST_P2 = 4'd9, ST_P2P = 4'd10, ST_P3 = 4'd11;

    logic [3:0]   r_st, n_st;
    logic         r_dirty, n_dirty;
    logic [127:0] r_tw, n_tw, r_htw, n_htw, r_hblk, n_hblk, r_x, n_x;
    logic         r_held, n_held, r_mode, n_mode;
    t_item        r_cur, n_cur;

    t_res         r_of [2];
    logic         r_owp, r_orp;
    logic [1:0]   r_ocnt;
    logic         w_push, w_opop, w_space;
    t_res         w_res;

    logic [127:0] w_blk, w_mask, w_a, w_b, w_x, w_mulx;

    assign w_blk   = {r_cur.data_hi, r_cur.data_lo};
    assign w_a     = r_mode ? r_htw : r_tw;
    assign w_b     = r_mode ? r_tw : r_htw;
    assign w_x     = i_aes_dout ^ w_a;
    assign w_mulx  = {r_tw[126:0], 1'b0} ^ (r_tw[127] ? GF_POLY : '0);
    assign w_space = (r_ocnt != 2'd2);

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            w_mask[8*j +: 8] = (5'(j) < r_cur.valid_bytes) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        n_st         = r_st;
        n_dirty      = r_dirty | i_cfg_wr;
        n_tw         = r_tw;
        n_htw        = r_htw;
        n_hblk       = r_hblk;
        n_x          = r_x;
        n_held       = r_held;
        n_mode       = r_mode;
        n_cur        = r_cur;
        o_pop        = 1'b0;
        o_kexp_start = 1'b0;
        o_aes_req    = '0;
        o_aes_din    = '0;
        w_push       = 1'b0;
        w_res        = '0;
        unique case (r_st)
            ST_IDLE: begin
                if (r_dirty) begin
                    o_kexp_start = 1'b1;
                    n_dirty      = i_cfg_wr;
                    n_st         = ST_KEY;
                end else if (i_item_valid) begin
                    o_pop = 1'b1;
                    n_cur = i_item;
                    if (i_item.first_block) begin
                        n_held           = 1'b0;
                        n_mode           = i_item.do_encrypt;
                        o_aes_req.start  = 1'b1;
                        o_aes_req.enc    = 1'b1;
                        o_aes_req.sel_tw = 1'b1;
                        o_aes_din        = {i_item.iv_hi, i_item.iv_lo};
                        n_st             = ST_TWK;
                    end else begin
                        n_tw = w_mulx;
                        n_st = ST_DISP;
                    end
                end
            end
            ST_KEY: begin
                if (!i_kexp_busy) begin
                    n_st = ST_IDLE;
                end
            end
            ST_TWK: begin
                if (i_aes_done) begin
                    n_tw = i_aes_dout;
                    n_st = ST_DISP;
                end
            end
            ST_DISP: begin
                if (r_cur.partial) begin
                    if (!r_held) begin
                        // sector shorter than one block
                        if (w_space) begin
                            w_push          = 1'b1;
                            w_res.out_last  = 1'b1;
                            w_res.error     = 1'b1;
                            n_st            = ST_IDLE;
                        end
                    end else begin
                        o_aes_req.start = 1'b1;
                        o_aes_req.enc   = r_mode;
                        o_aes_din       = r_hblk ^ w_a;
                        n_st            = ST_P1;
                    end
                end else if (r_held) begin
                    o_aes_req.start = 1'b1;
                    o_aes_req.enc   = r_mode;
                    o_aes_din       = r_hblk ^ r_htw;
                    n_st            = ST_H;
                end else if (r_cur.last_block) begin
                    o_aes_req.start = 1'b1;
                    o_aes_req.enc   = r_mode;
                    o_aes_din       = w_blk ^ r_tw;
                    n_st            = ST_L;
                end else begin
                    n_hblk = w_blk;
                    n_htw  = r_tw;
                    n_held = 1'b1;
                    n_st   = ST_IDLE;
                end
            end
            ST_H: begin
                if (i_aes_done) begin
                    n_st = ST_HP;
                end
            end
            ST_HP: begin
                if (w_space) begin
                    w_push          = 1'b1;
                    w_res.out_lo    = i_aes_dout[63:0] ^ r_htw[63:0];
                    w_res.out_hi    = i_aes_dout[127:64] ^ r_htw[127:64];
                    w_res.out_bytes = FULL_BYTES;
                    if (r_cur.last_block) begin
                        o_aes_req.start = 1'b1;
                        o_aes_req.enc   = r_mode;
                        o_aes_din       = w_blk ^ r_tw;
                        n_st            = ST_L;
                    end else begin
                        n_hblk = w_blk;
                        n_htw  = r_tw;
                        n_held = 1'b1;
                        n_st   = ST_IDLE;
                    end
                end
            end
            ST_L: begin
                if (i_aes_done) begin
                    n_st = ST_LP;
                end
            end
            ST_LP: begin
                if (w_space) begin
                    w_push          = 1'b1;
                    w_res.out_lo    = i_aes_dout[63:0] ^ r_tw[63:0];
                    w_res.out_hi    = i_aes_dout[127:64] ^ r_tw[127:64];
                    w_res.out_bytes = FULL_BYTES;
                    w_res.out_last  = 1'b1;
                    n_held          = 1'b0;
                    n_st            = ST_IDLE;
                end
            end
            ST_P1: begin
                // steal the tail of the first pass into the partial block
                if (i_aes_done) begin
                    n_x             = w_x;
                    o_aes_req.start = 1'b1;
                    o_aes_req.enc   = r_mode;
                    o_aes_din       = ((w_blk & w_mask) | (w_x & ~w_mask)) ^ w_b;
                    n_st            = ST_P2;
                end
            end
            ST_P2: begin
                if (i_aes_done) begin
                    n_st = ST_P2P;
                end
            end
            ST_P2P: begin
                if (w_space) begin
                    w_push          = 1'b1;
                    w_res.out_lo    = i_aes_dout[63:0] ^ w_b[63:0];
                    w_res.out_hi    = i_aes_dout[127:64] ^ w_b[127:64];
                    w_res.out_bytes = FULL_BYTES;
                    n_st            = ST_P3;
                end
            end
            ST_P3: begin
                if (w_space) begin
                    w_push          = 1'b1;
                    w_res.out_lo    = r_x[63:0] & w_mask[63:0];
                    w_res.out_hi    = r_x[127:64] & w_mask[127:64];
                    w_res.out_bytes = r_cur.valid_bytes;
                    w_res.out_last  = 1'b1;
                    n_held          = 1'b0;
                    n_st            = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_dirty <= 1'b1;
            r_tw    <= '0;
            r_held  <= 1'b0;
            r_mode  <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_dirty <= n_dirty;
            r_tw    <= n_tw;
            r_held  <= n_held;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_htw  <= n_htw;
        r_hblk <= n_hblk;
        r_x    <= n_x;
        r_cur  <= n_cur;
    end

    // result queue
    assign w_opop      = o_res_valid && i_res_ready;
    assign o_res_valid = (r_ocnt != 2'd0);
    assign o_res       = r_of[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(w_push) - 2'(w_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_of[r_owp] <= w_res;
        end
    end

endmodule

[hdl/xts_chk.sv]
// xts_chk: port-level checks on the result channel of the sector cipher
// bound to xts_aes_sector_cipher_core; no package dependency
module xts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_out_lo,
    input logic [63:0] o_out_hi,
    input logic [4:0]  o_out_bytes,
    input logic        o_out_last,
    input logic        o_error
);

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_out_bytes == 5'd0 && o_out_last
                                   && o_out_lo == 64'd0 && o_out_hi == 64'd0)
        else $error("error result not in canonical form");

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> o_out_bytes != 5'd0 && o_out_bytes <= 5'd16)
        else $error("result byte count out of range");

    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_last |-> o_out_bytes == 5'd16 && !o_error)
        else $error("non-last result is not a full block");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_lo)
                                        && $stable(o_out_bytes))
        else $error("stalled result changed");

endmodule

bind xts_aes_sector_cipher_core xts_chk u_chk (.*);

[bench/xts_aes_sector_cipher_core_test.sv]
// xts_aes_sector_cipher_core_test: self-checking bench for the xts sector cipher
// drives block requests and apb key writes and checks each result block
// against an in-bench xts/aes predictor; depends only on the rtl top level
`timescale 1ns / 100ps

module xts_aes_sector_cipher_core_test;

    localparam int KEY_BITS   = 256;
    localparam int NK         = (KEY_BITS <= 128) ? 4 : (KEY_BITS <= 192) ? 6 : 8;
    localparam int NR         = NK + 6;
    localparam int LIMIT      = 900000;
    localparam int SETTLE     = 200;
    localparam int PHASES     = 5;
    localparam int PER_PHASE  = 250;

    typedef enum int {
        REG_DKEY0, REG_DKEY1, REG_DKEY2, REG_DKEY3,
        REG_TKEY0, REG_TKEY1, REG_TKEY2, REG_TKEY3
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] data_lo;
        logic [63:0] data_hi;
        logic [63:0] iv_lo;
        logic [63:0] iv_hi;
        logic        enc;
        logic        first;
        logic        last;
        logic [4:0]  nbytes;
    } t_block_req;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  nbytes;
        logic        last;
        logic        err;
    } t_block_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_block_req  in_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_lo, out_hi;
    logic [4:0]  out_bytes;
    logic        out_last, out_err;

    xts_aes_sector_cipher_core #(.KEY_BITS(KEY_BITS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_data_lo(in_req.data_lo), .i_data_hi(in_req.data_hi),
        .i_iv_lo(in_req.iv_lo), .i_iv_hi(in_req.iv_hi),
        .i_do_encrypt(in_req.enc), .i_first_block(in_req.first),
        .i_last_block(in_req.last), .i_valid_bytes(in_req.nbytes),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_lo(out_lo), .o_out_hi(out_hi), .o_out_bytes(out_bytes),
        .o_out_last(out_last), .o_error(out_err)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [7:0]   sb [256];
    logic [7:0]   isb [256];
    logic [63:0]  dkey [4];
    logic [63:0]  tkey [4];
    logic [7:0]   drk [240];
    logic [7:0]   trk [240];
    logic [127:0] cur_tweak;
    logic [127:0] held_data;
    logic [127:0] held_tw;
    logic         held_valid;
    logic         dir_enc;

    t_block_req   blocks_to_send [$];
    t_block_res   outstanding_blocks [$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           requests_sent = 0;
    int           errors_seen = 0;
    int           steals_seen = 0;
    int           cycles = 0;
    logic         quiet = 1'b0;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic void build_sbox();
        logic [7:0] inv, s;
        for (int i = 0; i < 256; i++) begin
            inv = 8'h00;
            if (i != 0) begin
                inv = 8'h01;
                for (int k = 0; k < 254; k++) inv = gmul(inv, i[7:0]);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[i] = s;
            isb[s] = i[7:0];
        end
    endfunction

    function automatic void expand_key(input logic [63:0] k [4], output logic [7:0] rk [240]);
        logic [7:0] t [4];
        logic [7:0] rc, s;
        rc = 8'h01;
        for (int i = 0; i < 240; i++) rk[i] = 8'h00;
        for (int i = 0; i < 4 * NK; i++) rk[i] = k[(i >> 3) & 3][8 * (i & 7) +: 8];
        for (int i = NK; i < 4 * (NR + 1); i++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[4 * (i - 1) + j];
            if (i % NK == 0) begin
                s = t[0];
                t[0] = sb[t[1]] ^ rc;
                t[1] = sb[t[2]];
                t[2] = sb[t[3]];
                t[3] = sb[s];
                rc = gmul(rc, 8'h02);
            end else if (NK > 6 && i % NK == 4) begin
                for (int j = 0; j < 4; j++) t[j] = sb[t[j]];
            end
            for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - NK) + j] ^ t[j];
        end
    endfunction

    function automatic logic [127:0] aes_pass(input logic [7:0] rk [240], input logic enc,
                                              input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) s[i] = blk[8 * i +: 8];
        if (enc) begin
            for (int i = 0; i < 16; i++) s[i] ^= rk[i];
            for (int r = 1; r <= NR; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++) t[w + 4 * c] = sb[s[w + 4 * ((c + w) & 3)]];
                if (r < NR) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        t[4*c]   = gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3;
                        t[4*c+1] = a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3;
                        t[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3);
                        t[4*c+3] = gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2);
                    end
                end
                for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16 * r + i];
            end
        end else begin
            for (int i = 0; i < 16; i++) s[i] ^= rk[16 * NR + i];
            for (int r = NR - 1; r >= 0; r--) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++) t[w + 4 * ((c + w) & 3)] = isb[s[w + 4 * c]];
                for (int i = 0; i < 16; i++) t[i] ^= rk[16 * r + i];
                if (r > 0) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        t[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
                                   ^ gmul(a3, 8'd9);
                        t[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
                                   ^ gmul(a3, 8'd13);
                        t[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
                                   ^ gmul(a3, 8'd11);
                        t[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
                                   ^ gmul(a3, 8'd14);
                    end
                end
                for (int i = 0; i < 16; i++) s[i] = t[i];
            end
        end
        for (int i = 0; i < 16; i++) res[8 * i +: 8] = s[i];
        return res;
    endfunction

    function automatic logic [127:0] xts_pass(input logic enc, input logic [127:0] tw,
                                              input logic [127:0] blk);
        return aes_pass(drk, enc, blk ^ tw) ^ tw;
    endfunction

    function automatic void push_result(input logic [127:0] v, input logic [4:0] n,
                                        input logic last, input logic err);
        t_block_res r;
        r.lo = v[63:0];
        r.hi = v[127:64];
        r.nbytes = n;
        r.last = last;
        r.err = err;
        outstanding_blocks.push_back(r);
    endfunction

    // works out the result blocks caused by one accepted request
    function automatic void cipher_block(input t_block_req q);
        logic [127:0] data, mask, cc, pp, r0;
        int           n;
        data = {q.data_hi, q.data_lo};
        n = int'(q.nbytes);
        if (n == 0 || n > 16 || !q.last) n = 16;
        if (q.first) begin
            dir_enc = q.enc;
            held_valid = 1'b0;
            cur_tweak = aes_pass(trk, 1'b1, {q.iv_hi, q.iv_lo});
        end else begin
            cur_tweak = {cur_tweak[126:0], 1'b0} ^ (cur_tweak[127] ? 128'h87 : 128'h0);
        end
        if (n < 16) begin
            if (!held_valid) begin
                push_result('0, 5'd0, 1'b1, 1'b1);
                errors_seen++;
                return;
            end
            mask = (128'h1 << (8 * n)) - 128'h1;
            // ciphertext stealing: the partial tail borrows bytes of the held block
            if (dir_enc) begin
                cc = xts_pass(1'b1, held_tw, held_data);
                pp = (data & mask) | (cc & ~mask);
                r0 = xts_pass(1'b1, cur_tweak, pp);
                push_result(r0, 5'd16, 1'b0, 1'b0);
                push_result(cc & mask, n[4:0], 1'b1, 1'b0);
            end else begin
                pp = xts_pass(1'b0, cur_tweak, held_data);
                cc = (data & mask) | (pp & ~mask);
                r0 = xts_pass(1'b0, held_tw, cc);
                push_result(r0, 5'd16, 1'b0, 1'b0);
                push_result(pp & mask, n[4:0], 1'b1, 1'b0);
            end
            steals_seen++;
            held_valid = 1'b0;
            return;
        end
        if (held_valid) push_result(xts_pass(dir_enc, held_tw, held_data), 5'd16, 1'b0, 1'b0);
        if (q.last) begin
            push_result(xts_pass(dir_enc, cur_tweak, data), 5'd16, 1'b1, 1'b0);
            held_valid = 1'b0;
        end else begin
            held_data = data;
            held_tw = cur_tweak;
            held_valid = 1'b1;
        end
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_block_req make_block(input logic enc, input logic first,
                                              input logic last, input logic [4:0] n);
        t_block_req q;
        q.data_lo = rand64();
        q.data_hi = rand64();
        q.iv_lo = rand64();
        q.iv_hi = rand64();
        q.enc = enc;
        q.first = first;
        q.last = last;
        q.nbytes = n;
        return q;
    endfunction

    function automatic logic [4:0] rand_tail();
        case ($urandom_range(0, 9))
            0:       return 5'($urandom_range(17, 31));
            1:       return 5'd0;
            2, 3, 4: return 5'd16;
            default: return 5'($urandom_range(1, 15));
        endcase
    endfunction

    // well-formed sector: first, a few middle blocks, a last block
    function automatic int queue_sector(input int mids);
        logic enc;
        enc = 1'($urandom_range(0, 1));
        blocks_to_send.push_back(make_block(enc, 1'b1, 1'b0, 5'd16));
        for (int i = 0; i < mids; i++)
            blocks_to_send.push_back(make_block(1'($urandom_range(0, 1)), 1'b0, 1'b0,
                                     ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'd16));
        blocks_to_send.push_back(make_block(enc, 1'b0, 1'b1, rand_tail()));
        return mids + 2;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx >= REG_TKEY0) tkey[idx - REG_TKEY0] = value;
        else dkey[idx] = value;
        expand_key(dkey, drk);
        expand_key(tkey, trk);
    endtask

    task automatic drain();
        while (blocks_to_send.size() != 0 || in_valid) @(posedge i_clk);
        while (outstanding_blocks.size() != 0) @(posedge i_clk);
        // a trailing first block yields nothing, so give the core time to finish it
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // request driver
    int         send_gap = 0;
    logic       send_calm = 1'b0;
    t_block_req next_req;
    logic       next_valid;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            next_valid = in_valid;
            next_req = in_req;
            if (in_valid && in_ready) begin
                cipher_block(in_req);
                requests_sent++;
                next_valid = 1'b0;
            end
            if (cycles % 256 == 0) send_calm = ($urandom_range(0, 2) == 0);
            if (!next_valid) begin
                if (send_gap == 0 && !quiet && !send_calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 18);
                if (send_gap > 0) begin
                    send_gap--;
                end else if (blocks_to_send.size() != 0) begin
                    next_req = blocks_to_send.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
            in_req <= next_req;
        end
    end

    // result monitor
    int         recv_gap = 0;
    int         long_hold = 0;
    logic       long_done = 1'b0;
    logic       recv_calm = 1'b0;
    logic       next_ready;
    t_block_res want;

    // one long receiver stall, counted down on its own
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!long_done && results_seen >= 300) begin
                long_done = 1'b1;
                long_hold = 600;
            end else if (long_hold > 0) begin
                long_hold--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (outstanding_blocks.size() == 0) begin
                    report("unexpected result lo", out_lo, '0);
                end else begin
                    want = outstanding_blocks.pop_front();
                    if (out_lo !== want.lo) report("out_lo", out_lo, want.lo);
                    if (out_hi !== want.hi) report("out_hi", out_hi, want.hi);
                    if (out_bytes !== want.nbytes)
                        report("out_bytes", 64'(out_bytes), 64'(want.nbytes));
                    if (out_last !== want.last)
                        report("out_last", 64'(out_last), 64'(want.last));
                    if (out_err !== want.err) report("error", 64'(out_err), 64'(want.err));
                end
                results_seen++;
            end
            if (cycles % 256 == 128) recv_calm = ($urandom_range(0, 2) == 0);
            if (long_hold > 0) begin
                next_ready = 1'b0;
            end else begin
                if (recv_gap == 0 && !quiet && !recv_calm && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 18);
                next_ready = (recv_gap == 0);
                if (recv_gap > 0) recv_gap--;
            end
            out_ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int queued;
        build_sbox();
        for (int k = 0; k < 4; k++) begin
            dkey[k] = '0;
            tkey[k] = '0;
        end
        expand_key(dkey, drk);
        expand_key(tkey, trk);
        cur_tweak = '0;
        held_valid = 1'b0;
        dir_enc = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short sector, stealing both ways, odd byte counts,
        // restart while holding, orphan continuation, mid-sector direction flip
        blocks_to_send.push_back(make_block(1'b1, 1'b1, 1'b1, 5'd5));
        blocks_to_send.push_back(make_block(1'b1, 1'b1, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b1, 1'b0, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b1, 1'b0, 1'b1, 5'd1));
        blocks_to_send.push_back(make_block(1'b0, 1'b1, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b0, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b0, 1'b1, 5'd15));
        blocks_to_send.push_back(make_block(1'b1, 1'b1, 1'b1, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b1, 1'b1, 5'd0));
        blocks_to_send.push_back(make_block(1'b1, 1'b1, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b1, 1'b0, 1'b0, 5'd3));
        blocks_to_send.push_back(make_block(1'b1, 1'b0, 1'b1, 5'd31));
        blocks_to_send.push_back(make_block(1'b1, 1'b1, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b1, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b1, 1'b0, 1'b1, 5'd8));
        blocks_to_send.push_back(make_block(1'b1, 1'b0, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b0, 1'b1, 5'd9));
        blocks_to_send.push_back(make_block(1'b1, 1'b1, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b0, 1'b0, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b0, 1'b1, 5'd16));
        blocks_to_send.push_back(make_block(1'b0, 1'b1, 1'b0, 5'd17));
        blocks_to_send.push_back(make_block(1'b0, 1'b0, 1'b1, 5'd7));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // key settings: all ones, all zeros, then random
            for (int k = 0; k < 4; k++) begin
                apb_write(t_reg_idx'(REG_DKEY0 + k), (ph == 0) ? '1 : (ph == 1) ? '0 : rand64());
                apb_write(t_reg_idx'(REG_TKEY0 + k), (ph == 0) ? '1 : (ph == 1) ? '0 : rand64());
            end
            quiet = (ph == PHASES - 1);
            queued = 0;
            while (queued < PER_PHASE) begin
                if ($urandom_range(0, 4) != 0) begin
                    queued += queue_sector($urandom_range(0, 4));
                end else begin
                    blocks_to_send.push_back(make_block(1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 5'($urandom)));
                    queued++;
                end
                // sender pause until everything has come back
                if (ph == 2 && queued >= PER_PHASE / 2 && queued < PER_PHASE / 2 + 8) begin
                    while (blocks_to_send.size() != 0 || in_valid) @(posedge i_clk);
                    while (outstanding_blocks.size() != 0) @(posedge i_clk);
                    queued += 8;
                end
                if (blocks_to_send.size() > 16)
                    while (blocks_to_send.size() > 4) @(posedge i_clk);
            end
            drain();
        end

        $display("sent %0d requests, checked %0d results (%0d short-sector errors, %0d steals)",
                 requests_sent, results_seen, errors_seen, steals_seen);
        $display("key settings: reset, all ones, all zeros and %0d random", PHASES - 2);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/xts_pkg.sv
hdl/xts_front.sv
hdl/xts_kexp.sv
hdl/xts_aes.sv
hdl/xts_back.sv
hdl/xts_aes_sector_cipher_core.sv
hdl/xts_chk.sv
bench/xts_aes_sector_cipher_core_test.sv
